[src/si128bcd_pkg.sv]
`timescale 1ns / 1ps

package si128bcd_pkg;

	// Width of the signed input and of its magnitude.
	localparam int BIN_W = 128;

	// Decimal digits kept; 2^128 - 1 has 39 of them.
	localparam int DIGIT_COUNT = 39;
	localparam int BCD_W = DIGIT_COUNT * 4;
	localparam int COUNT_W = 6;

	// Shift-and-adjust steps, split evenly over the pipeline.
	localparam int STEP_COUNT = BIN_W;
	localparam int STEPS_PER_STAGE = 8;
	localparam int STAGE_COUNT = STEP_COUNT / STEPS_PER_STAGE;

	// Input register, dabble stages, digit count register.
	localparam int LATENCY = STAGE_COUNT + 2;

	localparam logic [3:0] ADJ_MIN = 4'd5;
	localparam logic [3:0] ADJ_ADD = 4'd3;

	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [BIN_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} work_t;

	// Add 3 to every digit of 5 or more.
	function automatic logic [BCD_W-1:0] adjust_digits(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		logic [3:0]       nib;
		res = bcd;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			nib = bcd[4*k +: 4];
			if (nib >= ADJ_MIN) begin
				res[4*k +: 4] = nib + ADJ_ADD;
			end
		end
		return res;
	endfunction

	// One double dabble step: adjust, then shift the magnitude into the digits.
	function automatic work_t dabble_step(input work_t w);
		work_t            res;
		logic [BCD_W-1:0] adj;
		res = w;
		adj = adjust_digits(w.bcd);
		{res.bcd, res.bin} = {adj[BCD_W-2:0], w.bin, 1'b0};
		return res;
	endfunction

endpackage

[src/si128bcd_dabble_stage.sv]
`timescale 1ns / 1ps

module si128bcd_dabble_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  si128bcd_pkg::work_t  in_word,
	output si128bcd_pkg::work_t  out_word
);

	si128bcd_pkg::work_t next_word;
	logic                valid_s;
	si128bcd_pkg::work_t work_s;

	always_comb begin
		next_word = in_word;
		for (int i = 0; i < si128bcd_pkg::STEPS_PER_STAGE; i++) begin
			next_word = si128bcd_pkg::dabble_step(next_word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else begin
			valid_s <= in_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_word.valid) begin
			work_s <= next_word;
		end
	end

	always_comb begin
		out_word       = work_s;
		out_word.valid = valid_s;
	end

endmodule

[src/si128bcd_count_stage.sv]
`timescale 1ns / 1ps

module si128bcd_count_stage (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  si128bcd_pkg::work_t                   in_word,
	output logic                                  done,
	output logic                                  negative,
	output logic [si128bcd_pkg::BCD_W-1:0]        digits,
	output logic [si128bcd_pkg::COUNT_W-1:0]      digit_count
);

	logic [si128bcd_pkg::COUNT_W-1:0] count_c;
	logic                             valid_s;
	logic                             neg_s;
	logic [si128bcd_pkg::BCD_W-1:0]   digits_s;
	logic [si128bcd_pkg::COUNT_W-1:0] count_s;

	// Position of the highest nonzero digit; zero still counts as one digit.
	always_comb begin
		count_c = si128bcd_pkg::COUNT_W'(1);
		for (int i = 0; i < si128bcd_pkg::DIGIT_COUNT; i++) begin
			if (in_word.bcd[4*i +: 4] != 4'd0) begin
				count_c = si128bcd_pkg::COUNT_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else begin
			valid_s <= in_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_word.valid) begin
			neg_s    <= in_word.neg;
			digits_s <= in_word.bcd;
			count_s  <= count_c;
		end
	end

	assign done        = valid_s;
	assign negative    = neg_s;
	assign digits      = digits_s;
	assign digit_count = count_s;

endmodule

[src/signed_int128_to_bcd_top.sv]
`timescale 1ns / 1ps

// Signed 128-bit binary to BCD converter.
// Input channel: a word (value_high, value_low) is taken at a rising clock edge
// where start is high and busy is low. busy never rises, so a new word may be
// given in every cycle. The value is two's complement; value_high holds the sign.
// Output channel: done is high for exactly one cycle with negative, the 39 BCD
// digits (digits_low holds the least significant sixteen, digit 1 in bits 3..0,
// then digits_mid and digits_top) and digit_count, the number of significant
// digits, which is one for zero. The most negative value converts exactly.
// Between the accepting edge and done, a word passes in order through
// an input register that takes the magnitude, sixteen stages that each run eight
// of the 128 shift-and-adjust steps, and a register that counts the digits.
// Throughput is one word per cycle; the sixteen dabble stages set the pipeline depth.
// The receiver cannot stall, so results are shown once and must be taken then.
// Reset clears every valid bit at once; words in flight are dropped and no done
// strobe appears until a new word has gone through the whole pipeline.
module signed_int128_to_bcd_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [63:0] value_high,
	input  logic        [63:0] value_low,
	output logic               done,
	output logic               negative,
	output logic        [63:0] digits_low,
	output logic        [63:0] digits_mid,
	output logic        [27:0] digits_top,
	output logic        [5:0]  digit_count
);

	logic                                  accept;
	logic                                  valid_s1;
	logic                                  neg_s1;
	logic [si128bcd_pkg::BIN_W-1:0]        mag_s1;
	logic [si128bcd_pkg::BIN_W-1:0]        value_c;
	si128bcd_pkg::work_t                   pipe [0:si128bcd_pkg::STAGE_COUNT];
	logic [si128bcd_pkg::BCD_W-1:0]        digits;

	// Every stage advances each cycle, so the block is always ready.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign value_c = {value_high, value_low};

	// First stage: split off the sign and take the magnitude. Negating the
	// most negative value wraps to 2^127, which is its true magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= value_high[63];
			mag_s1 <= value_high[63] ? (~value_c + si128bcd_pkg::BIN_W'(1)) : value_c;
		end
	end

	always_comb begin
		pipe[0].valid = valid_s1;
		pipe[0].neg   = neg_s1;
		pipe[0].bin   = mag_s1;
		pipe[0].bcd   = '0;
	end

	// The dabble chain; each stage registers its eight steps.
	for (genvar g = 0; g < si128bcd_pkg::STAGE_COUNT; g++) begin : g_dabble
		si128bcd_dabble_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_word  (pipe[g]),
			.out_word (pipe[g+1])
		);
	end

	si128bcd_count_stage u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_word     (pipe[si128bcd_pkg::STAGE_COUNT]),
		.done        (done),
		.negative    (negative),
		.digits      (digits),
		.digit_count (digit_count)
	);

	assign digits_low = digits[63:0];
	assign digits_mid = digits[127:64];
	assign digits_top = digits[155:128];

endmodule

[src/si128bcd_checker.sv]
`timescale 1ns / 1ps

module si128bcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        negative,
	input logic [63:0] digits_low,
	input logic [63:0] digits_mid,
	input logic [27:0] digits_top,
	input logic [5:0]  digit_count
);

	// Every accepted word yields its result a fixed number of cycles later.
	ap_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(si128bcd_pkg::LATENCY) done)
		else $error("accepted word gave no result at the expected cycle");

	// No result without a word accepted at the matching cycle.
	ap_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, si128bcd_pkg::LATENCY))
		else $error("result without a matching accepted word");

	ap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (digit_count >= 6'd1 && digit_count <= 6'd39))
		else $error("digit count out of range");

	// The count agrees with where the nonzero digits sit.
	ap_count_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((digit_count <= 6'd16) == (digits_mid == 64'd0 && digits_top == 28'd0)))
		else $error("digit count disagrees with the upper digit fields");

	// A zero result is never flagged negative and counts as one digit.
	ap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && digits_low == 64'd0 && digits_mid == 64'd0 && digits_top == 28'd0)
		|-> (!negative && digit_count == 6'd1))
		else $error("zero result with a sign or a wrong digit count");

endmodule

bind signed_int128_to_bcd_top si128bcd_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.negative    (negative),
	.digits_low  (digits_low),
	.digits_mid  (digits_mid),
	.digits_top  (digits_top),
	.digit_count (digit_count)
);

[tb/sv/tb_signed_int128_to_bcd_top.sv]
`timescale 1ns / 1ps

module tb_signed_int128_to_bcd_top;

	// The run gives up after this many cycles. A correct run offers about 1970
	// words with random gaps and then drains the pipeline.
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 1950;
	// Mismatches past this count are still counted but no longer printed.
	localparam int REPORT_LIMIT = 40;

	// One input word as the two halves of the signed 128-bit value.
	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} value_word_t;

	// One conversion result as the block should present it.
	typedef struct {
		logic        negative;
		logic [63:0] digits_low;
		logic [63:0] digits_mid;
		logic [27:0] digits_top;
		logic [5:0]  digit_count;
	} bcd_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [63:0] value_high = '0;
	logic        [63:0] value_low = '0;
	logic               done;
	logic               negative;
	logic        [63:0] digits_low;
	logic        [63:0] digits_mid;
	logic        [27:0] digits_top;
	logic        [5:0]  digit_count;

	// Words waiting to be offered, and conversions waiting for their done strobe.
	value_word_t word_queue[$];
	bcd_result_t bcd_queue[$];

	int          words_taken = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	value_word_t taken_word;
	bcd_result_t seen_result;
	bcd_result_t want_result;
	logic        idle_now;

	signed_int128_to_bcd_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value_high  (value_high),
		.value_low   (value_low),
		.done        (done),
		.negative    (negative),
		.digits_low  (digits_low),
		.digits_mid  (digits_mid),
		.digits_top  (digits_top),
		.digit_count (digit_count)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Expected conversion of a signed 128-bit value. The magnitude is taken
	// modulo 2^128, so the most negative value yields 2^127. Double dabble runs
	// on a 40-digit register: every digit of 5 or more gets 3 added before each
	// shift except the first. The fortieth digit always ends at zero.
	function automatic bcd_result_t predict_bcd(input logic [127:0] value);
		bcd_result_t res;
		logic [127:0] mag;
		logic [159:0] bcd;
		logic [5:0]   count;
		mag = value[127] ? (~value + 128'd1) : value;
		bcd = '0;
		for (int step = 0; step < 128; step++) begin
			if (step > 0) begin
				for (int d = 0; d < 40; d++) begin
					if (bcd[4*d +: 4] >= 4'd5) begin
						bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
					end
				end
			end
			bcd = {bcd[158:0], mag[127]};
			mag = mag << 1;
		end
		// Position of the highest nonzero digit; zero still counts as one digit.
		count = 6'd1;
		for (int d = 0; d < si128bcd_pkg::DIGIT_COUNT; d++) begin
			if (bcd[4*d +: 4] != 4'd0) begin
				count = 6'(d + 1);
			end
		end
		res.negative = value[127];
		res.digits_low = bcd[63:0];
		res.digits_mid = bcd[127:64];
		res.digits_top = bcd[155:128];
		res.digit_count = count;
		return res;
	endfunction

	function automatic logic [127:0] random_value128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic queue_value(input logic [127:0] value);
		value_word_t w;
		w.hi = value[127:64];
		w.lo = value[63:0];
		word_queue.push_back(w);
	endtask

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		end
	endtask

	// Driver. A word is taken at an edge where start is high and busy is low;
	// its conversion is predicted at that edge from the word that was on the
	// ports. The next word is then put up unless this cycle is an idle one.
	// Idle cycles show random noise on the value ports with start low. Words
	// 700 to 1099 go through back to back with no idling at all.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				taken_word = word_queue.pop_front();
				bcd_queue.push_back(predict_bcd({taken_word.hi, taken_word.lo}));
				words_taken++;
			end
			idle_now = !(words_taken >= 700 && words_taken < 1100) &&
				($urandom_range(99) < 13);
			if (word_queue.size() > 0 && !idle_now) begin
				start <= 1'b1;
				value_high <= word_queue[0].hi;
				value_low <= word_queue[0].lo;
			end else begin
				start <= 1'b0;
				value_high <= {$urandom, $urandom};
				value_low <= {$urandom, $urandom};
			end
		end
	end

	// Monitor. A done strobe lasts a single cycle and cannot be held off, so each
	// one is checked at the edge that ends its cycle against the oldest
	// outstanding prediction. A strobe with nothing outstanding is a failure.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			seen_result.negative = negative;
			seen_result.digits_low = digits_low;
			seen_result.digits_mid = digits_mid;
			seen_result.digits_top = digits_top;
			seen_result.digit_count = digit_count;
			if (bcd_queue.size() == 0) begin
				mismatch_count++;
				$display("%0t: done strobe with no word outstanding, actual %h %h %h %h %0d",
					$time, seen_result.negative, seen_result.digits_top,
					seen_result.digits_mid, seen_result.digits_low,
					seen_result.digit_count);
			end else begin
				want_result = bcd_queue.pop_front();
				report_field("negative", 64'(want_result.negative), 64'(seen_result.negative));
				report_field("digits_low", want_result.digits_low, seen_result.digits_low);
				report_field("digits_mid", want_result.digits_mid, seen_result.digits_mid);
				report_field("digits_top", 64'(want_result.digits_top),
					64'(seen_result.digits_top));
				report_field("digit_count", 64'(want_result.digit_count),
					64'(seen_result.digit_count));
			end
		end
	end

	// Watchdog: a hung pipeline or a lost strobe ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words pending and %0d results outstanding",
				$time, word_queue.size(), bcd_queue.size());
			$display("status: fail");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [127:0] pow10[0:38];
		logic [127:0] v;
		int           k;
		int           shape;

		pow10[0] = 128'd1;
		for (int i = 1; i <= 38; i++) begin
			pow10[i] = pow10[i-1] * 128'd10;
		end

		// Directed words: zero, small values, the signed extremes (the most
		// negative value has no positive counterpart), the carry between the two
		// halves, and the boundaries where the digit count crosses into
		// digits_mid, digits_top and the thirty-ninth digit.
		queue_value(128'd0);
		queue_value(128'd1);
		queue_value(~128'd0);
		queue_value(128'd9);
		queue_value(128'd10);
		queue_value({1'b1, 127'd0});
		queue_value({1'b0, {127{1'b1}}});
		queue_value({64'd0, {64{1'b1}}});
		queue_value({64'd1, 64'd0});
		queue_value(-{64'd1, 64'd0});
		queue_value(pow10[16] - 128'd1);
		queue_value(pow10[16]);
		queue_value(pow10[32] - 128'd1);
		queue_value(pow10[32]);
		queue_value(pow10[38] - 128'd1);
		queue_value(pow10[38]);
		queue_value(-pow10[38]);
		queue_value(-(pow10[38] - 128'd1));
		queue_value({32{4'h5}});
		queue_value({32{4'hA}});

		// Random words. Fully random values reach every bit but almost always
		// have 38 or 39 digits, so the rest are cut to a random bit length or
		// placed just around a power of ten, each with a random sign.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			shape = $urandom_range(9);
			if (shape < 4) begin
				v = random_value128();
			end else if (shape < 7) begin
				v = random_value128() >> $urandom_range(127);
				if ($urandom_range(1) == 1) begin
					v = -v;
				end
			end else begin
				k = $urandom_range(38);
				v = pow10[k] + 128'($urandom_range(4)) - 128'd2;
				if ($urandom_range(1) == 1) begin
					v = -v;
				end
			end
			queue_value(v);
		end

		// Reset is held from the start and released on a clock edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word to be taken and every result to arrive, then give
		// the pipeline its full depth again so a stray strobe would show up.
		while (word_queue.size() > 0 || bcd_queue.size() > 0) begin
			@(posedge clk);
		end
		repeat (si128bcd_pkg::LATENCY + 4) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
src/si128bcd_pkg.sv
src/si128bcd_dabble_stage.sv
src/si128bcd_count_stage.sv
src/signed_int128_to_bcd_top.sv
src/si128bcd_checker.sv
tb/sv/tb_signed_int128_to_bcd_top.sv
